FILE: rtl/bmie_pkg.sv
// ----------------------------------------------------------------------------
// bmie_pkg: shared types for the byte memory instruction executor
// Opcodes, sequencer states, the result beat and the divider request/response bundles.
// ----------------------------------------------------------------------------
package bmie_pkg;

  localparam int unsigned STORE_BYTES_DEF = 256;
  localparam int unsigned DIV_W           = 16;  // dividend / quotient width
  localparam int unsigned BYTE_W          = 8;

  typedef enum logic [4:0] {
    OP_LDI  = 5'd0,  OP_MOV = 5'd1,  OP_ADD = 5'd2,  OP_SUB = 5'd3,
    OP_MUL  = 5'd4,  OP_DIV = 5'd5,  OP_MOD = 5'd6,  OP_AND = 5'd7,
    OP_OR   = 5'd8,  OP_NOT = 5'd9,  OP_XOR = 5'd10, OP_SHR = 5'd11,
    OP_SHL  = 5'd12, OP_JMP = 5'd13, OP_EQ  = 5'd14, OP_GT  = 5'd15,
    OP_LT   = 5'd16, OP_IF  = 5'd17, OP_MIN = 5'd18, OP_MAX = 5'd19,
    OP_GCD  = 5'd20, OP_LCM = 5'd21, OP_HLT = 5'd22, OP_PUT = 5'd23,
    OP_GET  = 5'd24
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RDB, S_LDY, S_ALU, S_MULW, S_GCD, S_GCDW, S_DIVW
  } state_t;

  // result beat, lowest field last in declaration order
  typedef struct packed {
    logic              div_error;
    logic              halted;
    logic              skip_next;
    logic [BYTE_W-1:0] jump_line;
    logic              jump_taken;
    logic [BYTE_W-1:0] out_value;
    logic              out_valid;
  } result_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIV_W-1:0]  dividend;
    logic signed [BYTE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DIV_W-1:0]  quot;
    logic signed [BYTE_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: rtl/bmie_ram.sv
// ----------------------------------------------------------------------------
// bmie_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module bmie_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/bmie_div.sv
// ----------------------------------------------------------------------------
// bmie_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating
// quotient and remainder with the sign of the dividend.
// ----------------------------------------------------------------------------
module bmie_div (
  input  logic               clk,
  input  logic               rst_n,
  input  bmie_pkg::div_req_t req,
  output bmie_pkg::div_rsp_t rsp
);

  localparam int unsigned DW = bmie_pkg::DIV_W;
  localparam int unsigned BW = bmie_pkg::BYTE_W;

  logic                   busy_r, done_r;
  logic [$clog2(DW)-1:0]  cnt_r;
  logic [DW-1:0]          q_r;
  logic [BW-1:0]          rem_r, bmag_r;
  logic                   negq_r, negr_r;
  logic [BW:0]            sh;
  logic                   ge;

  assign sh = {rem_r, q_r[DW-1]};
  assign ge = sh >= {1'b0, bmag_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == $clog2(DW)'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r    <= req.dividend[DW-1] ? DW'(-req.dividend) : DW'(req.dividend);
      bmag_r <= req.divisor[BW-1] ? BW'(-req.divisor) : BW'(req.divisor);
      rem_r  <= '0;
      negq_r <= req.dividend[DW-1] ^ req.divisor[BW-1];
      negr_r <= req.dividend[DW-1];
    end else if (busy_r) begin
      rem_r <= ge ? BW'(sh - {1'b0, bmag_r}) : sh[BW-1:0];
      q_r   <= {q_r[DW-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = negq_r ? -$signed(q_r) : $signed(q_r);
  assign rsp.rem  = negr_r ? -$signed(rem_r) : $signed(rem_r);

endmodule

FILE: rtl/byte_memory_instruction_executor.sv
// ----------------------------------------------------------------------------
// byte_memory_instruction_executor: memory-to-memory byte instruction engine
// Reads two store bytes, runs one opcode through a shared divider and ALU,
// writes any result byte back and returns one status beat per instruction.
// ----------------------------------------------------------------------------
// Sequence: read A, read B, then the ALU state; mul adds a product write
// state, div/mod wait on the divider, gcd/lcm run one divider pass per Euclid
// step (one more for lcm); halted beats finish at accept. Throughput: one
// instruction at a time; the next beat is taken once the result beat has left.
// Reset: sync active-low; clears sequencer, halt flag and output valid.
// Store contents are undefined until written.
module byte_memory_instruction_executor #(
  parameter int unsigned STORE_BYTES = bmie_pkg::STORE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [4:0] req_type, [12:5] operand_a, [20:13] operand_b, [28:21] in_value
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] out_valid, [8:1] out_value, [9] jump_taken, [17:10] jump_line,
  // [18] skip_next, [19] halted, [20] div_error
  output logic [23:0] out_tdata
);

  localparam int unsigned AW = $clog2(STORE_BYTES);

  bmie_pkg::state_t state_r, state_nxt;
  bmie_pkg::op_t    op_r, op_nxt;
  logic [AW-1:0]    ia_r, ia_nxt, ib_r, ib_nxt;
  logic [7:0]       imm_r, imm_nxt;
  logic signed [7:0]  val_r, val_nxt, x_r, x_nxt, y_r, y_nxt, m_r, m_nxt, n_r, n_nxt;
  logic signed [15:0] prod_r, prod_nxt;
  logic             halt_r, halt_nxt, ovld_r, ovld_nxt;
  bmie_pkg::result_t res_r, res_nxt, rr;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;
  bmie_pkg::div_req_t dreq;
  bmie_pkg::div_rsp_t drsp;
  logic              fin, wv;
  logic [7:0]        wd;

  // operand address reduction, constant table
  logic [AW-1:0] amap [256];
  for (genvar i = 0; i < 256; i++) begin : g_amap
    assign amap[i] = AW'(i % STORE_BYTES);
  end

  bmie_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  bmie_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_tready  = (state_r == bmie_pkg::S_IDLE) && !ovld_r;
  assign out_tvalid = ovld_r;
  assign out_tdata  = {3'b000, res_r};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmie_pkg::S_IDLE;
      halt_r  <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      halt_r  <= halt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r <= op_nxt;  ia_r <= ia_nxt;  ib_r <= ib_nxt;  imm_r <= imm_nxt;
    val_r <= val_nxt; x_r <= x_nxt;  y_r <= y_nxt;   m_r <= m_nxt;
    n_r <= n_nxt;    prod_r <= prod_nxt; res_r <= res_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r; op_nxt = op_r; ia_nxt = ia_r; ib_nxt = ib_r;
    imm_nxt = imm_r; val_nxt = val_r; x_nxt = x_r; y_nxt = y_r;
    m_nxt = m_r; n_nxt = n_r; prod_nxt = prod_r; halt_nxt = halt_r;
    res_nxt = res_r;
    ovld_nxt = ovld_r && !out_tready;
    dreq = '0;
    fin = 1'b0; wv = 1'b0; wd = '0;
    rr = '0;
    rr.halted = halt_r;

    case (state_r)
      bmie_pkg::S_IDLE: begin
        if (in_tvalid && in_tready) begin
          op_nxt  = bmie_pkg::op_t'(in_tdata[4:0]);
          ia_nxt  = amap[in_tdata[12:5]];
          ib_nxt  = amap[in_tdata[20:13]];
          imm_nxt = in_tdata[20:13];
          val_nxt = in_tdata[28:21];
          if (halt_r) begin
            fin = 1'b1;
          end else begin
            state_nxt = bmie_pkg::S_RDB;
          end
        end
      end
      bmie_pkg::S_RDB: begin
        x_nxt = ram_rdata;
        state_nxt = bmie_pkg::S_LDY;
      end
      bmie_pkg::S_LDY: begin
        y_nxt = ram_rdata;
        state_nxt = bmie_pkg::S_ALU;
      end
      bmie_pkg::S_ALU: begin
        prod_nxt = x_r * y_r;
        fin = 1'b1;
        case (op_r)
          bmie_pkg::OP_LDI: begin wv = 1'b1; wd = imm_r; end
          bmie_pkg::OP_MOV: begin wv = 1'b1; wd = y_r; end
          bmie_pkg::OP_ADD: begin wv = 1'b1; wd = 8'(x_r + y_r); end
          bmie_pkg::OP_SUB: begin wv = 1'b1; wd = 8'(x_r - y_r); end
          bmie_pkg::OP_MUL: begin
            fin = 1'b0;
            state_nxt = bmie_pkg::S_MULW;
          end
          bmie_pkg::OP_DIV, bmie_pkg::OP_MOD: begin
            if (y_r == 8'sd0) begin
              rr.div_error = 1'b1;
            end else begin
              fin = 1'b0;
              dreq.start = 1'b1;
              dreq.dividend = 16'(x_r);
              dreq.divisor = y_r;
              state_nxt = bmie_pkg::S_DIVW;
            end
          end
          bmie_pkg::OP_AND: begin wv = 1'b1; wd = x_r & y_r; end
          bmie_pkg::OP_OR:  begin wv = 1'b1; wd = x_r | y_r; end
          bmie_pkg::OP_NOT: begin wv = 1'b1; wd = ~x_r; end
          bmie_pkg::OP_XOR: begin wv = 1'b1; wd = x_r ^ y_r; end
          bmie_pkg::OP_SHR: begin
            wv = 1'b1;
            wd = (y_r[7:3] != 5'd0) ? {8{x_r[7]}} : 8'(x_r >>> y_r[2:0]);
          end
          bmie_pkg::OP_SHL: begin
            wv = 1'b1;
            wd = (y_r[7:3] != 5'd0) ? 8'd0 : 8'(x_r << y_r[2:0]);
          end
          bmie_pkg::OP_JMP: begin rr.jump_taken = 1'b1; rr.jump_line = x_r; end
          bmie_pkg::OP_EQ:  begin wv = 1'b1; wd = {7'd0, x_r == y_r}; end
          bmie_pkg::OP_GT:  begin wv = 1'b1; wd = {7'd0, x_r > y_r}; end
          bmie_pkg::OP_LT:  begin wv = 1'b1; wd = {7'd0, x_r < y_r}; end
          bmie_pkg::OP_IF:  rr.skip_next = ~x_r[0];
          bmie_pkg::OP_MIN: begin wv = 1'b1; wd = (x_r > y_r) ? y_r : x_r; end
          bmie_pkg::OP_MAX: begin wv = 1'b1; wd = (x_r > y_r) ? x_r : y_r; end
          bmie_pkg::OP_GCD, bmie_pkg::OP_LCM: begin
            fin = 1'b0;
            m_nxt = x_r;
            n_nxt = y_r;
            state_nxt = bmie_pkg::S_GCD;
          end
          bmie_pkg::OP_HLT: begin halt_nxt = 1'b1; rr.halted = 1'b1; end
          bmie_pkg::OP_PUT: begin rr.out_valid = 1'b1; rr.out_value = x_r; end
          bmie_pkg::OP_GET: begin wv = 1'b1; wd = val_r; end
          default: ;
        endcase
      end
      bmie_pkg::S_MULW: begin
        wv = 1'b1; wd = prod_r[7:0]; fin = 1'b1;
      end
      bmie_pkg::S_GCD: begin
        if (n_r == 8'sd0) begin
          if (op_r == bmie_pkg::OP_GCD) begin
            wv = 1'b1; wd = m_r; fin = 1'b1;
          end else if (m_r == 8'sd0) begin
            rr.div_error = 1'b1; fin = 1'b1;
          end else begin
            dreq.start = 1'b1;
            dreq.dividend = prod_r;
            dreq.divisor = m_r;
            state_nxt = bmie_pkg::S_DIVW;
          end
        end else begin
          dreq.start = 1'b1;
          dreq.dividend = 16'(m_r);
          dreq.divisor = n_r;
          state_nxt = bmie_pkg::S_GCDW;
        end
      end
      bmie_pkg::S_GCDW: begin
        if (drsp.done) begin
          m_nxt = n_r;
          n_nxt = drsp.rem;
          state_nxt = bmie_pkg::S_GCD;
        end
      end
      bmie_pkg::S_DIVW: begin
        if (drsp.done) begin
          wv = 1'b1;
          wd = (op_r == bmie_pkg::OP_MOD) ? drsp.rem : drsp.quot[7:0];
          fin = 1'b1;
        end
      end
      default: state_nxt = bmie_pkg::S_IDLE;
    endcase

    if (fin) begin
      res_nxt   = rr;
      ovld_nxt  = 1'b1;
      state_nxt = bmie_pkg::S_IDLE;
    end
  end

  // store port: A on accept, then B, then write-back at A
  always_comb begin
    ram_we    = wv;
    ram_wdata = wd;
    case (state_r)
      bmie_pkg::S_IDLE: ram_addr = amap[in_tdata[12:5]];
      bmie_pkg::S_RDB:  ram_addr = ib_r;
      default:          ram_addr = ia_r;
    endcase
  end

endmodule

FILE: verif/byte_memory_instruction_executor_test.sv
// ----------------------------------------------------------------------------
// byte_memory_instruction_executor_test: self-checking bench for the executor
// Drives instruction beats with random gaps, predicts each status beat from a
// local copy of the byte store and halt flag, and compares field by field.
// ----------------------------------------------------------------------------
module byte_memory_instruction_executor_test;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  // predictor state
  logic [7:0]        store_img [256];
  bit                written [256];
  bit                halt_seen;
  bmie_pkg::result_t status_q [$];
  int                errors;

  always #5 clk = ~clk;

  byte_memory_instruction_executor u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // truncating Euclid on signed values
  function automatic int euclid_loop(int m, int n);
    int t;
    while (n != 0) begin
      t = m % n;
      m = n;
      n = t;
    end
    return m;
  endfunction

  // compute the status beat and update the store image and halt flag
  function automatic bmie_pkg::result_t predict_status(logic [4:0] op, logic [7:0] a,
                                                       logic [7:0] b, logic [7:0] v);
    bmie_pkg::result_t res;
    int x, y, r, g;
    int unsigned cnt;
    bit wr;
    res = '0;
    x = $signed(store_img[a]);
    y = $signed(store_img[b]);
    cnt = store_img[b];
    wr = 1'b0;
    r = 0;
    if (halt_seen) begin
      res.halted = 1'b1;
      return res;
    end
    case (op)
      bmie_pkg::OP_LDI: begin r = $signed(b); wr = 1; end
      bmie_pkg::OP_MOV: begin r = y; wr = 1; end
      bmie_pkg::OP_ADD: begin r = x + y; wr = 1; end
      bmie_pkg::OP_SUB: begin r = x - y; wr = 1; end
      bmie_pkg::OP_MUL: begin r = x * y; wr = 1; end
      bmie_pkg::OP_DIV: if (y == 0) res.div_error = 1; else begin r = x / y; wr = 1; end
      bmie_pkg::OP_MOD: if (y == 0) res.div_error = 1; else begin r = x % y; wr = 1; end
      bmie_pkg::OP_AND: begin r = x & y; wr = 1; end
      bmie_pkg::OP_OR:  begin r = x | y; wr = 1; end
      bmie_pkg::OP_NOT: begin r = ~x; wr = 1; end
      bmie_pkg::OP_XOR: begin r = x ^ y; wr = 1; end
      bmie_pkg::OP_SHR: begin
        r = (cnt >= 8) ? ((x < 0) ? -1 : 0) : (x >>> cnt);
        wr = 1;
      end
      bmie_pkg::OP_SHL: begin r = (cnt >= 8) ? 0 : ((x << cnt) & 255); wr = 1; end
      bmie_pkg::OP_JMP: begin res.jump_taken = 1; res.jump_line = store_img[a]; end
      bmie_pkg::OP_EQ:  begin r = (x == y); wr = 1; end
      bmie_pkg::OP_GT:  begin r = (x > y); wr = 1; end
      bmie_pkg::OP_LT:  begin r = (x < y); wr = 1; end
      bmie_pkg::OP_IF:  res.skip_next = ~store_img[a][0];
      bmie_pkg::OP_MIN: begin r = (x > y) ? y : x; wr = 1; end
      bmie_pkg::OP_MAX: begin r = (x > y) ? x : y; wr = 1; end
      bmie_pkg::OP_GCD: begin r = euclid_loop(x, y); wr = 1; end
      bmie_pkg::OP_LCM: begin
        g = euclid_loop(x, y);
        g = $signed(g[7:0]);
        if (g == 0) res.div_error = 1; else begin r = (x * y) / g; wr = 1; end
      end
      bmie_pkg::OP_HLT: halt_seen = 1'b1;
      bmie_pkg::OP_PUT: begin res.out_valid = 1; res.out_value = store_img[a]; end
      bmie_pkg::OP_GET: begin r = $signed(v); wr = 1; end
      default: ;
    endcase
    if (wr) begin
      store_img[a] = r[7:0];
      written[a] = 1'b1;
    end
    res.halted = halt_seen;
    return res;
  endfunction

  // send one instruction beat and queue its expected status; valid stays up
  // only when the next beat follows in the same step
  task automatic send_instr(logic [4:0] op, logic [7:0] a, logic [7:0] b,
                            logic [7:0] v);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b0, v, b, a, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    status_q = {status_q, predict_status(op, a, b, v)};
  endtask

  // random written address, else the first written one, or address 0 if none yet
  function automatic logic [7:0] pick_written();
    logic [7:0] k;
    repeat (50) begin
      k = 8'($urandom_range(0, 255));
      if (written[k]) return k;
    end
    for (int i = 0; i < 256; i++) if (written[i]) return i[7:0];
    return 8'd0;
  endfunction

  task automatic load_byte(logic [7:0] a, logic [7:0] val);
    send_instr(bmie_pkg::OP_LDI, a, val, 8'($urandom));
  endtask

  // extremes of selected operations with directed operand bytes
  task automatic test_directed();
    logic [7:0] vals [6] = '{8'h80, 8'hFF, 8'h00, 8'h01, 8'h7F, 8'h08};
    foreach (vals[i]) load_byte(8'(i), vals[i]);
    load_byte(8'hFF, 8'hAA);
    send_instr(bmie_pkg::OP_GET, 8'hFE, 8'h00, 8'h55);
    send_instr(bmie_pkg::OP_DIV, 8'd0, 8'd1, 8'h00);   // -128 / -1 wraps
    load_byte(8'd0, 8'h80);
    send_instr(bmie_pkg::OP_MOD, 8'd0, 8'd1, 8'h00);
    send_instr(bmie_pkg::OP_DIV, 8'd3, 8'd2, 8'h00);   // divide by zero
    load_byte(8'd0, 8'h80);
    send_instr(bmie_pkg::OP_GCD, 8'd0, 8'd2, 8'h00);   // gcd(-128,0)
    load_byte(8'd6, 8'h00);
    send_instr(bmie_pkg::OP_LCM, 8'd6, 8'd2, 8'h00);   // lcm of zeros
    send_instr(bmie_pkg::OP_SHR, 8'd1, 8'd5, 8'h00);   // shift count 8
    send_instr(bmie_pkg::OP_SHL, 8'd4, 8'd1, 8'h00);   // count 255
    send_instr(bmie_pkg::OP_JMP, 8'd4, 8'd0, 8'h00);
    send_instr(bmie_pkg::OP_IF, 8'd2, 8'd0, 8'h00);
    send_instr(bmie_pkg::OP_PUT, 8'hFE, 8'd0, 8'h00);
    send_instr(5'd31, 8'd3, 8'd3, 8'h00);              // unused opcode
  endtask

  // random instructions over written bytes
  task automatic test_random(int count);
    logic [4:0] op;
    logic [7:0] a, b;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(0, 99) < 3) ? 5'($urandom_range(25, 31))
                                       : 5'($urandom_range(0, 21));
      if ($urandom_range(0, 9) < 2)
        op = ($urandom_range(0, 1) != 0) ? bmie_pkg::OP_PUT : bmie_pkg::OP_GET;
      if (op == bmie_pkg::OP_LDI || op == bmie_pkg::OP_GET) begin
        a = 8'($urandom);
        send_instr(op, a, 8'($urandom), 8'($urandom));
      end else begin
        a = pick_written();
        b = pick_written();
        // keep bytes small sometimes so gcd/div see friendly values
        if ($urandom_range(0, 3) == 0) load_byte(b, 8'($urandom_range(0, 3) - 1));
        send_instr(op, a, b, 8'($urandom));
      end
    end
  endtask

  // halt, then items that must be ignored
  task automatic test_halt();
    send_instr(bmie_pkg::OP_HLT, 8'd0, 8'd0, 8'h00);
    for (int n = 0; n < 8; n++)
      send_instr(5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // result sink with random stalls
  always @(posedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(0, 9) < 7) ? 1'b1 :
                             (gap_len() == 0);
  end

  always @(posedge clk) begin
    bmie_pkg::result_t got, exp_s;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[20:0];
      if (status_q.size() == 0) begin
        $display("%0t unexpected beat %h", $time, got);
        errors++;
      end else begin
        exp_s = status_q.pop_front();
        if (got.out_valid !== exp_s.out_valid || got.out_value !== exp_s.out_value ||
            got.jump_taken !== exp_s.jump_taken || got.jump_line !== exp_s.jump_line ||
            got.skip_next !== exp_s.skip_next || got.halted !== exp_s.halted ||
            got.div_error !== exp_s.div_error) begin
          $display("%0t mismatch expected %h actual %h", $time, exp_s, got);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    errors = 0;
    halt_seen = 0;
    foreach (written[i]) written[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(830);
    test_halt();
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && status_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
